FILE: rtl/button_press_classifier_macros.svh
// Assertion macros used by the checker file of the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while reset is low.
`define BPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("button_press_classifier: check failed");

// Next-cycle implication, sampled on the rising clock, off while reset is low.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("button_press_classifier: check failed");

`endif

FILE: rtl/bpc_pkg.sv
// Shared types and constants of the button press classifier.
package bpc_pkg;

	// Command carried with each input word.
	typedef enum logic {
		CMD_TICK = 1'b0,
		CMD_READ = 1'b1
	} cmd_t;

	// Configuration port geometry.
	localparam int THR_BITS      = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int REG_IDX_BITS  = 3;

	// Register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_SHORT_TICKS  = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_LONG_TICKS   = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_REPEAT_TICKS = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_REPEAT_MASK  = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_INPUT_MASK   = 3'd4;

	// Reset values of the timing registers.
	localparam logic [THR_BITS-1:0] SHORT_TICKS_RST  = 16'd20;
	localparam logic [THR_BITS-1:0] LONG_TICKS_RST   = 16'd600;
	localparam logic [THR_BITS-1:0] REPEAT_TICKS_RST = 16'd150;
	localparam int REPEAT_MASK_RST = 6;
	localparam int INPUT_MASK_RST  = 31;

	// Timing thresholds handed to the classifier core.
	typedef struct packed {
		logic [THR_BITS-1:0] short_ticks;
		logic [THR_BITS-1:0] long_ticks;
		logic [THR_BITS-1:0] repeat_ticks;
	} thr_t;

endpackage

FILE: rtl/button_press_classifier.sv
// Top level of the button press classifier: input stage, config registers, result register.
//
//  channel   | direction | accepted when        | contents
//  ----------+-----------+----------------------+---------------------------------------
//  s_*       | in        | s_tvalid & s_tready  | tuser: cmd, tdata: pressed_mask
//  m_*       | out       | m_tvalid & m_tready  | tdata: button_code, long_flag
//  cfg_*     | in        | cfg_wen              | cfg_idx selects register, cfg_wdata
//
// One word is taken per clock cycle while s_tready is high. A word waits in the input stage;
// as it leaves, the counter and latched command update and a read lands in the result register.
// The result register is the only place that stalls: while it holds an untaken word, a
// further read waits in the input stage and holds s_tready low, ticks pass freely.
// Reset clears the counter, the latched command and both valid flags, and loads the
// register defaults 20, 600, 150, 6, 31.
module button_press_classifier #(
	parameter int INPUT_BITS = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// slave side
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((INPUT_BITS+7)/8)*8-1:0]       s_tdata,  // pressed_mask
	input  logic                                  s_tuser,  // cmd
	// master side
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((INPUT_BITS+8)/8)*8-1:0]       m_tdata,  // button_code, long_flag
	// configuration write port
	input  logic                                  cfg_wen,
	input  logic [bpc_pkg::REG_IDX_BITS-1:0]      cfg_idx,
	input  logic [bpc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
	import bpc_pkg::*;

	localparam int OUT_BITS = ((INPUT_BITS + 8) / 8) * 8;

	// Configuration registers.
	thr_t                  thr_q;
	logic [INPUT_BITS-1:0] repeat_mask_q;
	logic [INPUT_BITS-1:0] input_mask_q;

	// Input stage.
	logic                  valid_s1;
	logic                  cmd_s1;
	logic [INPUT_BITS-1:0] mask_s1;

	// Result register.
	logic                  out_valid_q;
	logic [INPUT_BITS-1:0] out_code_q;
	logic                  out_long_q;

	logic                  is_read_s1, out_free, fire_s1, accept;
	logic [INPUT_BITS-1:0] core_code;
	logic                  core_long;

	// A tick never waits; a read waits only for room in the result register.
	assign is_read_s1 = valid_s1 && (cmd_s1 == CMD_READ);
	assign out_free   = !out_valid_q || m_tready;
	assign fire_s1    = valid_s1 && (!is_read_s1 || out_free);
	assign s_tready   = !valid_s1 || fire_s1;
	assign accept     = s_tvalid && s_tready;

	// Register writes; unknown indexes drop.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.short_ticks  <= SHORT_TICKS_RST;
			thr_q.long_ticks   <= LONG_TICKS_RST;
			thr_q.repeat_ticks <= REPEAT_TICKS_RST;
			repeat_mask_q      <= INPUT_BITS'(REPEAT_MASK_RST);
			input_mask_q       <= INPUT_BITS'(INPUT_MASK_RST);
		end else if (cfg_wen) begin
			case (cfg_idx)
				REG_SHORT_TICKS:  thr_q.short_ticks  <= cfg_wdata[THR_BITS-1:0];
				REG_LONG_TICKS:   thr_q.long_ticks   <= cfg_wdata[THR_BITS-1:0];
				REG_REPEAT_TICKS: thr_q.repeat_ticks <= cfg_wdata[THR_BITS-1:0];
				REG_REPEAT_MASK:  repeat_mask_q      <= cfg_wdata[INPUT_BITS-1:0];
				REG_INPUT_MASK:   input_mask_q       <= cfg_wdata[INPUT_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage valid: load on accept, drop once the word has been worked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload: hold while stalled.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= s_tuser;
			mask_s1 <= s_tdata[INPUT_BITS-1:0];
		end
	end

	bpc_core #(
		.INPUT_BITS (INPUT_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (fire_s1),
		.cmd         (cmd_s1),
		.sample      (mask_s1),
		.thr         (thr_q),
		.repeat_mask (repeat_mask_q),
		.input_mask  (input_mask_q),
		.code        (core_code),
		.long_flag   (core_long)
	);

	// Result register: capture the latched command on a read, clear valid when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && is_read_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && is_read_s1) begin
			out_code_q <= core_code;
			out_long_q <= core_long;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_BITS'({out_long_q, out_code_q});

endmodule

FILE: rtl/bpc_core.sv
// Press counter, short/long/autorepeat decision and latched command of the classifier.
module bpc_core #(
	parameter int INPUT_BITS = 5,
	parameter int COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic                  cmd,
	input  logic [INPUT_BITS-1:0] sample,
	input  bpc_pkg::thr_t         thr,
	input  logic [INPUT_BITS-1:0] repeat_mask,
	input  logic [INPUT_BITS-1:0] input_mask,
	output logic [INPUT_BITS-1:0] code,
	output logic                  long_flag
);
	import bpc_pkg::*;

	// Compare width: room for count plus a 16-bit threshold without overflow.
	localparam int CW = ((COUNT_BITS > THR_BITS) ? COUNT_BITS : THR_BITS) + 1;

	logic [COUNT_BITS-1:0] press_count_q, press_count_d;
	logic [INPUT_BITS-1:0] prev_mask_q, prev_mask_d;
	logic [INPUT_BITS-1:0] lat_code_q, lat_code_d;
	logic                  lat_long_q, lat_long_d;

	logic [INPUT_BITS-1:0] now_mask;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [CW-1:0]         inc_ext, cnt_ext, short_ext, long_ext, rep_ext;

	assign now_mask  = sample & input_mask;
	assign cnt_inc   = (press_count_q == {COUNT_BITS{1'b1}}) ? press_count_q
	                                                         : press_count_q + 1'b1;
	assign inc_ext   = CW'(cnt_inc);
	assign cnt_ext   = CW'(press_count_q);
	assign short_ext = CW'(thr.short_ticks);
	assign long_ext  = CW'(thr.long_ticks);
	assign rep_ext   = CW'(thr.repeat_ticks);

	always_comb begin
		press_count_d = press_count_q;
		prev_mask_d   = prev_mask_q;
		lat_code_d    = lat_code_q;
		lat_long_d    = lat_long_q;
		if (cmd == CMD_READ) begin
			lat_code_d = '0;
			lat_long_d = 1'b0;
		end else if (now_mask != '0) begin
			prev_mask_d = now_mask;
			if (now_mask == prev_mask_q) begin
				press_count_d = cnt_inc;
				if (inc_ext == long_ext) begin
					lat_code_d = prev_mask_q;
					lat_long_d = 1'b1;
					// Pull back for autorepeat, clamping at zero.
					if ((now_mask & repeat_mask) != '0) begin
						if (inc_ext >= rep_ext)
							press_count_d = COUNT_BITS'(inc_ext - rep_ext);
						else
							press_count_d = '0;
					end
				end
			end
		end else begin
			prev_mask_d   = '0;
			press_count_d = '0;
			if (cnt_ext > short_ext && (cnt_ext + rep_ext) < long_ext)
				lat_code_d = prev_mask_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_count_q <= '0;
			prev_mask_q   <= '0;
			lat_code_q    <= '0;
			lat_long_q    <= 1'b0;
		end else if (step) begin
			press_count_q <= press_count_d;
			prev_mask_q   <= prev_mask_d;
			lat_code_q    <= lat_code_d;
			lat_long_q    <= lat_long_d;
		end
	end

	assign code      = lat_code_q;
	assign long_flag = lat_long_q;

endmodule

FILE: rtl/bpc_checker.sv
// Port-level checks of the button press classifier and their bind.
`include "button_press_classifier_macros.svh"

module bpc_checker #(
	parameter int INPUT_BITS = 5
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            s_tuser,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [((INPUT_BITS+8)/8)*8-1:0] m_tdata
);
	import bpc_pkg::*;

	// A word waiting on the master side holds its data.
	`BPC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// With the result register empty, the slave side never stalls.
	`BPC_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !m_tvalid, s_tready)

	// A result appears only after a read has been taken and has passed through the input stage.
	`BPC_ASSERT_SAME(a_result_from_read, clk, arst_n, $rose(m_tvalid), $past(s_tvalid && s_tready && (s_tuser == CMD_READ), 2))

endmodule

bind button_press_classifier bpc_checker #(
	.INPUT_BITS (INPUT_BITS)
) u_bpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
